FILE: src/envelope_point_thinner_core_macros.svh
// ----------------------------------------------------------------------------
// envelope_point_thinner_core_macros.svh
// Assertion macros shared by the envelope point thinner RTL.
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_POINT_THINNER_CORE_MACROS_SVH
`define ENVELOPE_POINT_THINNER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define EPT_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next
`define EPT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/ept_pkg.sv
// ----------------------------------------------------------------------------
// ept_pkg
// Shared types and constants of the envelope point thinner.
// ----------------------------------------------------------------------------
package ept_pkg;

  // Default field widths
  localparam int TICK_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF  = 16;

  // Deviation threshold register
  localparam int              THRESH_BITS  = 16;
  localparam logic [15:0]     THRESH_RESET = 16'd131;

  // Width of the tick slice fed to the multiplier per step
  localparam int MUL_CHUNK = 32;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Classification of an accepted point
  typedef struct packed {
    logic has_anchor;  // a stream is open
    logic has_held;    // a middle point is waiting for this successor
    logic last;        // final point of the stream
  } cmd_flags_t;

  // Back-end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SETUP,
    ST_MUL,
    ST_ACC,
    ST_CMP,
    ST_KEEP,
    ST_FINISH
  } state_t;

  // Which product the multiplier is working on
  typedef enum logic [1:0] {
    PROD_A,    // (p.v - k.v) * span
    PROD_B,    // (n.v - k.v) * dt
    PROD_LIM   // threshold * span
  } prod_sel_t;

endpackage

FILE: src/ept_front.sv
// ----------------------------------------------------------------------------
// ept_front
// Accepts points and tags each with its place in the stream.
// ----------------------------------------------------------------------------
module ept_front
  import ept_pkg::*;
#(
  parameter int TICK_BITS  = TICK_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TICK_BITS-1:0]  in_tick,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_last,
  input  logic                  q_ready,
  output logic                  q_push,
  output logic [TICK_BITS-1:0]  q_tick,
  output logic [VALUE_BITS-1:0] q_value,
  output cmd_flags_t            q_flags
);

  logic open_r, open_nxt;
  logic held_r, held_nxt;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;
  assign q_tick   = in_tick;
  assign q_value  = in_value;

  always_comb begin
    q_flags.has_anchor = open_r;
    q_flags.has_held   = held_r;
    q_flags.last       = in_last;
  end

  // Stream tracking: open after a first point, holding after a middle point
  always_comb begin
    open_nxt = open_r;
    held_nxt = held_r;
    if (q_push) begin
      if (!open_r) begin
        open_nxt = !in_last;
        held_nxt = 1'b0;
      end else if (in_last) begin
        open_nxt = 1'b0;
        held_nxt = 1'b0;
      end else begin
        held_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      held_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

FILE: src/ept_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ept_cmd_fifo
// Short command queue decoupling the front from the back end.
// ----------------------------------------------------------------------------
`include "envelope_point_thinner_core_macros.svh"

module ept_cmd_fifo
  import ept_pkg::*;
#(
  parameter int DATA_W = 51,
  parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              ready,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign ready    = (count_r != CNT_W'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `EPT_ASSERT_CLK(a_no_overflow, push |-> (count_r != CNT_W'(DEPTH)), "queue push while full")
  `EPT_ASSERT_CLK(a_no_underflow, pop |-> (count_r != '0), "queue pop while empty")
  `EPT_ASSERT_NEXT(a_count_step, push && !pop, count_r == $past(count_r) + 1'b1, "fill count lost")

endmodule

FILE: src/ept_back.sv
// ----------------------------------------------------------------------------
// ept_back
// Chord deviation test, anchor/held state and result output register.
// ----------------------------------------------------------------------------
`include "envelope_point_thinner_core_macros.svh"

module ept_back
  import ept_pkg::*;
#(
  parameter int TICK_BITS  = TICK_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  logic [TICK_BITS-1:0]   q_tick,
  input  logic [VALUE_BITS-1:0]  q_value,
  input  cmd_flags_t             q_flags,
  input  logic [THRESH_BITS-1:0] thresh,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TICK_BITS-1:0]   out_tick,
  output logic [VALUE_BITS-1:0]  out_value,
  output logic                   out_last
);

  localparam int MW    = (VALUE_BITS > THRESH_BITS) ? VALUE_BITS : THRESH_BITS;
  localparam int NCH   = (TICK_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PW    = NCH * MUL_CHUNK;
  localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PRW   = MW + MUL_CHUNK;
  localparam int DW    = MW + PW + 2;

  state_t                state_r, state_nxt;
  logic [TICK_BITS-1:0]  cmd_tick_r, cmd_tick_nxt;
  logic [VALUE_BITS-1:0] cmd_value_r, cmd_value_nxt;
  cmd_flags_t            cmd_flags_r, cmd_flags_nxt;
  logic [TICK_BITS-1:0]  anchor_tick_r, anchor_tick_nxt;
  logic [VALUE_BITS-1:0] anchor_value_r, anchor_value_nxt;
  logic [TICK_BITS-1:0]  held_tick_r, held_tick_nxt;
  logic [VALUE_BITS-1:0] held_value_r, held_value_nxt;
  logic [PW-1:0]         span_r, span_nxt;
  logic [PW-1:0]         dt_r, dt_nxt;
  logic [MW-1:0]         pv_r, pv_nxt;
  logic [MW-1:0]         vv_r, vv_nxt;
  logic                  pn_r, pn_nxt;
  logic                  bsub_r, bsub_nxt;
  prod_sel_t             psel_r, psel_nxt;
  logic [CW-1:0]         chunk_r, chunk_nxt;
  logic [PRW-1:0]        prod_r, prod_nxt;
  logic [DW-1:0]         d_acc_r, d_acc_nxt;
  logic [DW-1:0]         lim_acc_r, lim_acc_nxt;
  logic                  keep_r, keep_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [TICK_BITS-1:0]  out_tick_r, out_tick_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  out_load;
  logic                  span_neg, dt_neg, pv_neg, vv_neg;
  logic [TICK_BITS-1:0]  span_mag, dt_mag;
  logic [VALUE_BITS-1:0] pv_mag, vv_mag, vdiff;
  logic [MW-1:0]         mul_a;
  logic [PW-1:0]         mul_t;
  logic [MUL_CHUNK-1:0]  chunk_val;
  logic [DW-1:0]         addend;
  logic [DW-1:0]         d_abs;

  assign out_valid = out_valid_r;
  assign out_tick  = out_tick_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_free  = !out_valid_r || out_ready;

  // Signed differences against the anchor, as sign and magnitude, and the held-to-successor value distance
  always_comb begin
    span_neg = cmd_tick_r < anchor_tick_r;
    span_mag = span_neg ? anchor_tick_r - cmd_tick_r : cmd_tick_r - anchor_tick_r;
    dt_neg   = held_tick_r < anchor_tick_r;
    dt_mag   = dt_neg ? anchor_tick_r - held_tick_r : held_tick_r - anchor_tick_r;
    pv_neg   = held_value_r < anchor_value_r;
    pv_mag   = pv_neg ? anchor_value_r - held_value_r : held_value_r - anchor_value_r;
    vv_neg   = cmd_value_r < anchor_value_r;
    vv_mag   = vv_neg ? anchor_value_r - cmd_value_r : cmd_value_r - anchor_value_r;
    vdiff    = (held_value_r > cmd_value_r) ? held_value_r - cmd_value_r
                                            : cmd_value_r - held_value_r;
  end

  // Multiplier operand selection: one tick slice per step
  always_comb begin
    case (psel_r)
      PROD_A: begin
        mul_a = pv_r;
        mul_t = span_r;
      end
      PROD_B: begin
        mul_a = vv_r;
        mul_t = dt_r;
      end
      PROD_LIM: begin
        mul_a = MW'(thresh);
        mul_t = span_r;
      end
      default: begin
        mul_a = '0;
        mul_t = '0;
      end
    endcase
    chunk_val = mul_t[chunk_r * MUL_CHUNK +: MUL_CHUNK];
    addend    = DW'(prod_r) << (chunk_r * MUL_CHUNK);
    d_abs     = d_acc_r[DW-1] ? (~d_acc_r + 1'b1) : d_acc_r;
  end

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    cmd_tick_nxt     = cmd_tick_r;
    cmd_value_nxt    = cmd_value_r;
    cmd_flags_nxt    = cmd_flags_r;
    anchor_tick_nxt  = anchor_tick_r;
    anchor_value_nxt = anchor_value_r;
    held_tick_nxt    = held_tick_r;
    held_value_nxt   = held_value_r;
    span_nxt         = span_r;
    dt_nxt           = dt_r;
    pv_nxt           = pv_r;
    vv_nxt           = vv_r;
    pn_nxt           = pn_r;
    bsub_nxt         = bsub_r;
    psel_nxt         = psel_r;
    chunk_nxt        = chunk_r;
    prod_nxt         = prod_r;
    d_acc_nxt        = d_acc_r;
    lim_acc_nxt      = lim_acc_r;
    keep_nxt         = keep_r;
    out_tick_nxt     = out_tick_r;
    out_value_nxt    = out_value_r;
    out_last_nxt     = out_last_r;
    out_load         = 1'b0;
    q_pop            = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          cmd_tick_nxt  = q_tick;
          cmd_value_nxt = q_value;
          cmd_flags_nxt = q_flags;
          if (!q_flags.has_anchor) begin
            state_nxt = ST_FIRST;
          end else if (q_flags.has_held) begin
            state_nxt = ST_SETUP;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end

      // First point of a stream passes and, unless it is also last, opens the anchor
      ST_FIRST: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_tick_nxt  = cmd_tick_r;
          out_value_nxt = cmd_value_r;
          out_last_nxt  = cmd_flags_r.last;
          if (!cmd_flags_r.last) begin
            anchor_tick_nxt  = cmd_tick_r;
            anchor_value_nxt = cmd_value_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      // Zero or negative span takes the plain value test
      ST_SETUP: begin
        if (span_neg || (span_mag == '0)) begin
          keep_nxt  = MW'(vdiff) > MW'(thresh);
          state_nxt = ST_KEEP;
        end else begin
          span_nxt    = PW'(span_mag);
          dt_nxt      = PW'(dt_mag);
          pv_nxt      = MW'(pv_mag);
          vv_nxt      = MW'(vv_mag);
          pn_nxt      = pv_neg;
          bsub_nxt    = (vv_neg == dt_neg);
          psel_nxt    = PROD_A;
          chunk_nxt   = '0;
          d_acc_nxt   = '0;
          lim_acc_nxt = '0;
          state_nxt   = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_nxt  = PRW'(mul_a) * PRW'(chunk_val);
        state_nxt = ST_ACC;
      end

      // Fold the partial product in at its slice position
      ST_ACC: begin
        case (psel_r)
          PROD_A:   d_acc_nxt = pn_r ? d_acc_r - addend : d_acc_r + addend;
          PROD_B:   d_acc_nxt = bsub_r ? d_acc_r - addend : d_acc_r + addend;
          PROD_LIM: lim_acc_nxt = lim_acc_r + addend;
          default:  d_acc_nxt = d_acc_r;
        endcase
        state_nxt = ST_MUL;
        if (chunk_r == CW'(NCH - 1)) begin
          chunk_nxt = '0;
          case (psel_r)
            PROD_A:   psel_nxt = PROD_B;
            PROD_B:   psel_nxt = PROD_LIM;
            default:  state_nxt = ST_CMP;
          endcase
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end

      ST_CMP: begin
        keep_nxt  = d_abs > lim_acc_r;
        state_nxt = ST_KEEP;
      end

      // A kept held point is emitted and becomes the anchor
      ST_KEEP: begin
        if (!keep_r) begin
          state_nxt = ST_FINISH;
        end else if (out_free) begin
          out_load         = 1'b1;
          out_tick_nxt     = held_tick_r;
          out_value_nxt    = held_value_r;
          out_last_nxt     = 1'b0;
          anchor_tick_nxt  = held_tick_r;
          anchor_value_nxt = held_value_r;
          state_nxt        = ST_FINISH;
        end
      end

      // End point is emitted; a middle point is held
      ST_FINISH: begin
        if (!cmd_flags_r.last) begin
          held_tick_nxt  = cmd_tick_r;
          held_value_nxt = cmd_value_r;
          state_nxt      = ST_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_tick_nxt  = cmd_tick_r;
          out_value_nxt = cmd_value_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    cmd_tick_r     <= cmd_tick_nxt;
    cmd_value_r    <= cmd_value_nxt;
    cmd_flags_r    <= cmd_flags_nxt;
    anchor_tick_r  <= anchor_tick_nxt;
    anchor_value_r <= anchor_value_nxt;
    held_tick_r    <= held_tick_nxt;
    held_value_r   <= held_value_nxt;
    span_r         <= span_nxt;
    dt_r           <= dt_nxt;
    pv_r           <= pv_nxt;
    vv_r           <= vv_nxt;
    pn_r           <= pn_nxt;
    bsub_r         <= bsub_nxt;
    psel_r         <= psel_nxt;
    chunk_r        <= chunk_nxt;
    prod_r         <= prod_nxt;
    d_acc_r        <= d_acc_nxt;
    lim_acc_r      <= lim_acc_nxt;
    keep_r         <= keep_nxt;
    out_tick_r     <= out_tick_nxt;
    out_value_r    <= out_value_nxt;
    out_last_r     <= out_last_nxt;
  end

  `EPT_ASSERT_CLK(a_pop_idle, q_pop |-> (state_r == ST_IDLE), "command taken while busy")
  `EPT_ASSERT_CLK(a_no_clobber, (out_load && out_valid_r) |-> out_ready, "result overwritten")
  `EPT_ASSERT_NEXT(a_cmp_keep, state_r == ST_CMP, state_r == ST_KEEP, "compare not followed by decision")
  `EPT_ASSERT_NEXT(a_anchor_moves, (state_r == ST_KEEP) && keep_r && out_free, anchor_tick_r == $past(held_tick_r), "anchor not moved to kept point")

endmodule

FILE: src/envelope_point_thinner_core.sv
// ----------------------------------------------------------------------------
// envelope_point_thinner_core
// Greedy thinning of an automation point stream against a chord deviation.
// ----------------------------------------------------------------------------
// Points enter on in_*, one transaction each; kept points leave on out_*.
// The first and last point of each stream always pass; a middle point is held
// until its successor arrives and is kept only if it deviates from the chord
// (last kept point to successor) by more than the threshold on cfg_*. The
// front classifies points into a two-entry command queue; the back end runs
// one command at a time. A held point with zero or negative span takes a plain
// value test against its successor; otherwise the test runs three products
// through one MUL_CHUNK-wide multiplier, a multiply and an accumulate step
// per 32-bit tick slice. The back end also stalls while out_tready holds back
// a pending result.
module envelope_point_thinner_core
  import ept_pkg::*;
#(
  parameter int TICK_BITS   = TICK_BITS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  // tdata, from bit 0: point_tick, point_value, zero fill
  input  logic [((TICK_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                                               in_tvalid,
  output logic                                               in_tready,
  input  logic                                               in_tlast,   // stream_end
  // tdata, from bit 0: kept_tick, kept_value, zero fill
  output logic [((TICK_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                                               out_tvalid,
  input  logic                                               out_tready,
  output logic                                               out_tlast,  // run_last
  input  logic [THRESH_BITS-1:0]                             cfg_data,   // deviation_threshold
  input  logic                                               cfg_valid,
  output logic                                               cfg_ready
);

  localparam int DATA_W = ((TICK_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int FLG_W  = $bits(cmd_flags_t);
  localparam int Q_W    = TICK_BITS + VALUE_BITS + FLG_W;

  logic [THRESH_BITS-1:0] thresh_r, thresh_nxt;
  logic                   f_push, q_ready, q_valid, q_pop;
  logic [TICK_BITS-1:0]   f_tick, b_tick, o_tick;
  logic [VALUE_BITS-1:0]  f_value, b_value, o_value;
  cmd_flags_t             f_flags, b_flags;
  logic [Q_W-1:0]         q_wdata, q_rdata;

  // Threshold register, writable at any time
  assign cfg_ready  = 1'b1;
  assign thresh_nxt = (cfg_valid && cfg_ready) ? cfg_data : thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else begin
      thresh_r <= thresh_nxt;
    end
  end

  ept_front #(
    .TICK_BITS  (TICK_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_tick  (in_tdata[TICK_BITS-1:0]),
    .in_value (in_tdata[TICK_BITS +: VALUE_BITS]),
    .in_last  (in_tlast),
    .q_ready  (q_ready),
    .q_push   (f_push),
    .q_tick   (f_tick),
    .q_value  (f_value),
    .q_flags  (f_flags)
  );

  // Command packing across the queue
  assign q_wdata = {f_tick, f_value, f_flags};
  assign b_tick  = q_rdata[Q_W-1 -: TICK_BITS];
  assign b_value = q_rdata[FLG_W +: VALUE_BITS];
  assign b_flags = cmd_flags_t'(q_rdata[FLG_W-1:0]);

  ept_cmd_fifo #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_wdata),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  ept_back #(
    .TICK_BITS  (TICK_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_tick    (b_tick),
    .q_value   (b_value),
    .q_flags   (b_flags),
    .thresh    (thresh_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tick  (o_tick),
    .out_value (o_value),
    .out_last  (out_tlast)
  );

  assign out_tdata = DATA_W'({o_value, o_tick});

endmodule
